[hdl/twsq_pkg.sv]
package twsq_pkg;

  localparam int SENSOR_COUNT = 6;
  localparam int SEL_W        = 3;
  localparam int WINDOW_DEPTH = 10;
  localparam int SAMPLE_W     = 16;
  localparam int TIME_W       = 32;
  localparam int CFG_ADDR_W   = 8;
  localparam int SENSOR_IDX_W = $clog2(SENSOR_COUNT);

  typedef logic [1:0]          class_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TIME_W-1:0]   stamp_t;
  typedef logic [SEL_W-1:0]    sel_t;
  typedef logic [SENSOR_IDX_W-1:0] sidx_t;

  localparam class_t CLASS_INVALID = 2'd0;
  localparam class_t CLASS_SAFE    = 2'd1;
  localparam class_t CLASS_UNSAFE  = 2'd2;
  localparam class_t CLASS_INITIAL = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_VALID_MIN = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_VALID_MAX = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT0    = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_LAST      = CFG_ADDR_W'(2 + SENSOR_COUNT - 1);

  // entry 0 is the oldest sample, entry WINDOW_DEPTH-1 the newest
  typedef logic [WINDOW_DEPTH-1:0][SAMPLE_W-1:0] window_t;

  typedef struct packed {
    class_t  cls;
    sample_t reading;
    stamp_t  stamp;
  } sensor_state_t;

  typedef struct packed {
    window_t row;
    logic    has_zero;
    logic    agree;
    class_t  first;
  } eval_res_t;

  localparam int STATE_W  = $bits(sensor_state_t);
  localparam int WINDOW_W = $bits(window_t);

endpackage

[hdl/twsq_ram.sv]
module twsq_ram #(
  parameter int DEPTH  = 6,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/twsq_eval.sv]
module twsq_eval (
  input  logic                 clk,
  input  logic                 en,
  input  twsq_pkg::window_t    old_row,
  input  twsq_pkg::sample_t    sample,
  input  twsq_pkg::sample_t    valid_min,
  input  twsq_pkg::sample_t    valid_max,
  input  twsq_pkg::sample_t    limit,
  output twsq_pkg::eval_res_t  res
);
  import twsq_pkg::*;

  window_t   row_shift;
  class_t    cls [WINDOW_DEPTH];
  eval_res_t res_nxt;

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      row_shift[i] = old_row[i+1];
    end
    row_shift[WINDOW_DEPTH-1] = sample;
  end

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (row_shift[i] < valid_min || row_shift[i] > valid_max) begin
        cls[i] = CLASS_INVALID;
      end else if (row_shift[i] > limit) begin
        cls[i] = CLASS_UNSAFE;
      end else begin
        cls[i] = CLASS_SAFE;
      end
    end
  end

  always_comb begin
    res_nxt.row      = row_shift;
    res_nxt.first    = cls[0];
    res_nxt.has_zero = 1'b0;
    res_nxt.agree    = 1'b1;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (row_shift[i] == '0) begin
        res_nxt.has_zero = 1'b1;
      end
      if (cls[i] != cls[0]) begin
        res_nxt.agree = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_nxt;
    end
  end

endmodule

[hdl/temperature_window_safety_qualifier_unit.sv]
// Per-sensor temperature qualifier for six sensors. Each input transaction
// carries a sensor select, a raw sample and a timestamp; the sample is shifted
// into that sensor's window of the last ten samples, the window is classed
// against the valid range and the sensor's limit, and one result transaction
// reports the sensor's class, last safe reading and its time. Windows and
// per-sensor state sit in two single-port-per-side RAMs with registered reads;
// an item passes through RAM read, window evaluation, then write-back and
// result load, which waits until out_tready frees the result register.
// Only one item is in flight, so write-back never races a read. Per-row valid
// flags reset at once, so no clearing pass is needed after reset. Selects six
// and seven change nothing and report class initial with zero data.
// Configuration writes are always taken; indexes above seven are ignored.
module temperature_window_safety_qualifier_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twsq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [twsq_pkg::SAMPLE_W-1:0]    cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,  // [15:0] sample_value, [47:16] time_stamp
  input  logic [twsq_pkg::SEL_W-1:0]       in_tuser,  // [2:0] sensor_select
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [55:0]                      out_tdata, // [1:0] safety_class,
                                                      // [17:2] valid_temperature,
                                                      // [49:18] update_time, [55:50] zero
  output logic [twsq_pkg::SEL_W-1:0]       out_tuser  // [2:0] sensor_echo
);
  import twsq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] st_r, st_nxt;

  sample_t valid_min_r, valid_max_r;
  sample_t limit_r [SENSOR_COUNT];

  sel_t    sel_r;
  sample_t sample_r;
  stamp_t  stamp_r;
  logic    sel_ok_r;

  logic [SENSOR_COUNT-1:0] row_vld_r;

  logic          in_acc;
  logic          in_sel_ok;
  sidx_t         rd_addr;
  sidx_t         sidx;
  window_t       win_rd;
  logic [STATE_W-1:0] st_rd_raw;
  sensor_state_t st_rd, st_old, st_new;
  window_t       win_eval_in;
  eval_res_t     ev;
  logic          mem_wr;
  logic          out_free;

  logic                out_valid_r;
  sel_t                out_sel_r;
  sensor_state_t       out_state_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_sel_ok = (in_tuser < SEL_W'(SENSOR_COUNT));
  assign rd_addr   = in_sel_ok ? in_tuser[SENSOR_IDX_W-1:0] : '0;
  assign sidx      = sel_r[SENSOR_IDX_W-1:0];
  assign out_free  = !out_valid_r || out_tready;
  assign mem_wr    = (st_r == ST_WRITE) && out_free && sel_ok_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_min_r <= '0;
      valid_max_r <= '1;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        limit_r[s] <= '1;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == REG_VALID_MIN) begin
        valid_min_r <= cfg_data;
      end else if (cfg_addr == REG_VALID_MAX) begin
        valid_max_r <= cfg_data;
      end else if (cfg_addr <= REG_LAST) begin
        limit_r[SENSOR_IDX_W'(cfg_addr - REG_LIMIT0)] <= cfg_data;
      end
    end
  end

  twsq_ram #(.DEPTH(SENSOR_COUNT), .WIDTH(WINDOW_W)) u_win_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (sidx),
    .wr_data (ev.row),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (win_rd)
  );

  twsq_ram #(.DEPTH(SENSOR_COUNT), .WIDTH(STATE_W)) u_state_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (sidx),
    .wr_data (STATE_W'(st_new)),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (st_rd_raw)
  );

  assign st_rd       = sensor_state_t'(st_rd_raw);
  // a row never written reads as its reset value
  assign win_eval_in = row_vld_r[sidx] ? win_rd : '0;

  twsq_eval u_eval (
    .clk       (clk),
    .en        (st_r == ST_EVAL),
    .old_row   (win_eval_in),
    .sample    (sample_r),
    .valid_min (valid_min_r),
    .valid_max (valid_max_r),
    .limit     (limit_r[sidx]),
    .res       (ev)
  );

  always_comb begin
    if (row_vld_r[sidx]) begin
      st_old = st_rd;
    end else begin
      st_old.cls     = CLASS_INITIAL;
      st_old.reading = '0;
      st_old.stamp   = '0;
    end
    st_new = st_old;
    if (!ev.has_zero) begin
      st_new.cls = ev.agree ? ev.first : CLASS_SAFE;
    end
    if (st_new.cls == CLASS_SAFE) begin
      st_new.reading = sample_r;
      st_new.stamp   = stamp_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_acc) st_nxt = ST_EVAL;
      ST_EVAL:  st_nxt = ST_WRITE;
      ST_WRITE: if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (mem_wr) begin
        row_vld_r[sidx] <= 1'b1;
      end
      if (st_r == ST_WRITE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel_r    <= in_tuser;
      sel_ok_r <= in_sel_ok;
      sample_r <= in_tdata[15:0];
      stamp_r  <= in_tdata[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_WRITE && out_free) begin
      out_sel_r <= sel_r;
      if (sel_ok_r) begin
        out_state_r <= st_new;
      end else begin
        out_state_r.cls     <= CLASS_INITIAL;
        out_state_r.reading <= '0;
        out_state_r.stamp   <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sel_r;
  assign out_tdata  = {6'b0, out_state_r.stamp, out_state_r.reading, out_state_r.cls};

endmodule
